[hdl/btwa_pkg.sv]
// Shared types and constants for the binned time-weighted average unit.
package btwa_pkg;

	localparam int NUM_BINS_DEF = 8;
	localparam int SAMPLE_W     = 24;
	localparam int STEP_W       = 16;
	localparam int PERIOD_W     = 16;
	localparam int AVG_W        = 24;
	localparam int PROD_W       = SAMPLE_W + STEP_W;
	localparam int SUM_W        = 48;
	localparam int TIME_W       = 32;
	localparam int WSUM_W       = 52;
	localparam int WTIME_W      = 35;
	localparam int DIV_STEPS    = WSUM_W;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_SWEEP,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic upd;
		logic sw_rd;
		logic sw_acc;
		logic div_init;
		logic div_step;
		logic fin;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_stat_t;

endpackage

[hdl/binned_time_weighted_average_unit.sv]
// Top level of the binned time-weighted average unit.
// An item is accepted only in idle; the block takes no new item until the last one has finished.
// The work for each item is set by the bin sweep through the single memory read port and the
// 52-step restoring divider.
// A waiting result does not block the next item; it blocks only the next result.
// Reset (arst_n low) empties all bins, selects bin 0 and sets bin_period to 1000.
module binned_time_weighted_average_unit #(
	parameter int NUM_BINS = btwa_pkg::NUM_BINS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [btwa_pkg::PERIOD_W-1:0]         bin_period,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  logic signed [btwa_pkg::SAMPLE_W-1:0]  sample,
	input  logic [btwa_pkg::STEP_W-1:0]           step_time,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic signed [btwa_pkg::AVG_W-1:0]     average,
	output logic                                  time_empty
);

	localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

	btwa_pkg::dp_cmd_t  cmd;
	btwa_pkg::dp_stat_t stat;
	logic [IDX_W-1:0]   sw_idx;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	btwa_ctrl #(
		.NUM_BINS (NUM_BINS),
		.IDX_W    (IDX_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd),
		.sw_idx     (sw_idx)
	);

	btwa_dp #(
		.NUM_BINS (NUM_BINS),
		.IDX_W    (IDX_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sw_idx       (sw_idx),
		.stat         (stat),
		.cfg_we       (cfg_valid & cfg_ready),
		.cfg_data     (bin_period),
		.sample       (sample),
		.step_time    (step_time),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.average      (average),
		.time_empty   (time_empty)
	);

endmodule

[hdl/btwa_ctrl.sv]
// Sequencer for bin update, window sweep, division and result hand-off.
module btwa_ctrl #(
	parameter int NUM_BINS = btwa_pkg::NUM_BINS_DEF,
	parameter int IDX_W    = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  btwa_pkg::dp_stat_t  stat,
	output btwa_pkg::dp_cmd_t   cmd,
	output logic [IDX_W-1:0]    sw_idx
);

	localparam int CNT_MAX = ((NUM_BINS + 1) > (btwa_pkg::DIV_STEPS + 1)) ?
		(NUM_BINS + 1) : (btwa_pkg::DIV_STEPS + 1);
	localparam int CNT_W = $clog2(CNT_MAX);

	btwa_pkg::state_t state_q, state_nx;
	logic [CNT_W-1:0] cnt_q;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			btwa_pkg::ST_IDLE: begin
				if (item_valid) state_nx = btwa_pkg::ST_UPD;
			end
			btwa_pkg::ST_UPD: state_nx = btwa_pkg::ST_SWEEP;
			btwa_pkg::ST_SWEEP: begin
				if (cnt_q == CNT_W'(NUM_BINS)) state_nx = btwa_pkg::ST_DIV;
			end
			btwa_pkg::ST_DIV: begin
				if (cnt_q == CNT_W'(btwa_pkg::DIV_STEPS)) state_nx = btwa_pkg::ST_FIN;
			end
			btwa_pkg::ST_FIN: begin
				if (!stat.out_busy) state_nx = btwa_pkg::ST_IDLE;
			end
			default: state_nx = btwa_pkg::ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd        = '0;
		item_stall = 1'b1;
		case (state_q)
			btwa_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				cmd.load   = item_valid;
			end
			btwa_pkg::ST_UPD: cmd.upd = 1'b1;
			btwa_pkg::ST_SWEEP: begin
				cmd.sw_rd  = (cnt_q < CNT_W'(NUM_BINS));
				cmd.sw_acc = (cnt_q != '0);
			end
			btwa_pkg::ST_DIV: begin
				cmd.div_init = (cnt_q == '0);
				cmd.div_step = (cnt_q != '0);
			end
			btwa_pkg::ST_FIN: cmd.fin = !stat.out_busy;
			default: cmd = '0;
		endcase
	end

	assign sw_idx = cnt_q[IDX_W-1:0];

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btwa_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_nx != state_q) cnt_q <= '0;
			else if (state_q == btwa_pkg::ST_SWEEP || state_q == btwa_pkg::ST_DIV)
				cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule

[hdl/btwa_dp.sv]
// Datapath: bin memory, window accumulators, restoring divider, result register.
module btwa_dp #(
	parameter int NUM_BINS = btwa_pkg::NUM_BINS_DEF,
	parameter int IDX_W    = 3
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  btwa_pkg::dp_cmd_t                     cmd,
	input  logic [IDX_W-1:0]                      sw_idx,
	output btwa_pkg::dp_stat_t                    stat,
	input  logic                                  cfg_we,
	input  logic [btwa_pkg::PERIOD_W-1:0]         cfg_data,
	input  logic signed [btwa_pkg::SAMPLE_W-1:0]  sample,
	input  logic [btwa_pkg::STEP_W-1:0]           step_time,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic signed [btwa_pkg::AVG_W-1:0]     average,
	output logic                                  time_empty
);

	localparam int SUM_W   = btwa_pkg::SUM_W;
	localparam int TIME_W  = btwa_pkg::TIME_W;
	localparam int WSUM_W  = btwa_pkg::WSUM_W;
	localparam int WTIME_W = btwa_pkg::WTIME_W;
	localparam int AVG_W   = btwa_pkg::AVG_W;
	localparam int ROW_W   = SUM_W + TIME_W;

	logic [btwa_pkg::PERIOD_W-1:0] period_q;
	logic [IDX_W-1:0]              cur_q;
	logic [NUM_BINS-1:0]           vld_q;
	logic [ROW_W-1:0]              mem [NUM_BINS];
	logic [ROW_W-1:0]              rdata_q;
	logic                          rvld_q;
	logic [IDX_W-1:0]              rd_addr;

	logic signed [btwa_pkg::PROD_W-1:0] prod_s1;
	logic [btwa_pkg::STEP_W-1:0]        dt_s1;

	logic signed [SUM_W-1:0] rd_sum;
	logic [TIME_W-1:0]       rd_time;
	logic                    adv;
	logic [IDX_W-1:0]        nxt_idx;
	logic signed [SUM_W-1:0] base_sum;
	logic [TIME_W-1:0]       base_time;
	logic signed [SUM_W:0]   sum_ext;
	logic [TIME_W:0]         time_ext;
	logic signed [SUM_W-1:0] new_sum;
	logic [TIME_W-1:0]       new_time;

	logic signed [WSUM_W-1:0] wsum_q;
	logic [WTIME_W-1:0]       wtime_q;
	logic signed [WSUM_W:0]   wsum_ext;
	logic [WTIME_W:0]         wtime_ext;

	logic [WSUM_W-1:0]  quo_q;
	logic [WTIME_W-1:0] rem_q;
	logic               neg_q;
	logic [WTIME_W:0]   rem_sh;
	logic [WSUM_W-1:0]  avg_lim;
	logic [AVG_W-1:0]   avg_val;

	logic                    out_vld_q;
	logic signed [AVG_W-1:0] avg_q;
	logic                    empty_q;

	// hold the bin period
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) period_q <= btwa_pkg::PERIOD_RESET;
		else if (cfg_we) period_q <= cfg_data;
	end

	// capture weighted sample and step of the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			prod_s1 <= sample * $signed({1'b0, step_time});
			dt_s1   <= step_time;
		end
	end

	// bin memory read port, registered
	assign rd_addr = cmd.sw_rd ? sw_idx : cur_q;

	always_ff @(posedge clk) begin
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rvld_q <= 1'b0;
		else rvld_q <= vld_q[rd_addr];
	end

	assign rd_sum  = rvld_q ? $signed(rdata_q[ROW_W-1:TIME_W]) : '0;
	assign rd_time = rvld_q ? rdata_q[TIME_W-1:0] : '0;

	// advance the ring when the open bin is full, then accumulate with saturation
	assign adv     = rd_time >= TIME_W'(period_q);
	assign nxt_idx = (cur_q == IDX_W'(NUM_BINS - 1)) ? '0 : cur_q + 1'b1;
	assign base_sum  = adv ? '0 : rd_sum;
	assign base_time = adv ? '0 : rd_time;
	assign sum_ext   = {base_sum[SUM_W-1], base_sum} + (SUM_W + 1)'(prod_s1);
	assign time_ext  = {1'b0, base_time} + (TIME_W + 1)'(dt_s1);

	always_comb begin
		new_sum = sum_ext[SUM_W-1:0];
		if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
			new_sum = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		new_time = time_ext[TIME_W] ? '1 : time_ext[TIME_W-1:0];
	end

	// bin memory write port
	always_ff @(posedge clk) begin
		if (cmd.upd) mem[adv ? nxt_idx : cur_q] <= {new_sum, new_time};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			cur_q <= '0;
		end else if (cmd.upd) begin
			vld_q[adv ? nxt_idx : cur_q] <= 1'b1;
			if (adv) cur_q <= nxt_idx;
		end
	end

	// window totals, saturating in bin order
	assign wsum_ext  = {wsum_q[WSUM_W-1], wsum_q} + (WSUM_W + 1)'(rd_sum);
	assign wtime_ext = {1'b0, wtime_q} + (WTIME_W + 1)'(rd_time);

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			wsum_q  <= '0;
			wtime_q <= '0;
		end else if (cmd.sw_acc) begin
			if (wsum_ext[WSUM_W] != wsum_ext[WSUM_W-1])
				wsum_q <= wsum_ext[WSUM_W] ? {1'b1, {(WSUM_W-1){1'b0}}} :
					{1'b0, {(WSUM_W-1){1'b1}}};
			else
				wsum_q <= wsum_ext[WSUM_W-1:0];
			wtime_q <= wtime_ext[WTIME_W] ? '1 : wtime_ext[WTIME_W-1:0];
		end
	end

	// restoring divider on magnitudes, one quotient bit per step
	assign rem_sh = {rem_q, quo_q[WSUM_W-1]};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			neg_q <= wsum_q[WSUM_W-1];
			quo_q <= wsum_q[WSUM_W-1] ? WSUM_W'(-wsum_q) : WSUM_W'(wsum_q);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_sh >= {1'b0, wtime_q}) begin
				rem_q <= WTIME_W'(rem_sh - {1'b0, wtime_q});
				quo_q <= {quo_q[WSUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[WTIME_W-1:0];
				quo_q <= {quo_q[WSUM_W-2:0], 1'b0};
			end
		end
	end

	// apply sign and clamp to the result range
	assign avg_lim = WSUM_W'(1) << (AVG_W - 1);

	always_comb begin
		if (wtime_q == '0) avg_val = '0;
		else if (neg_q) avg_val = (quo_q > avg_lim) ? {1'b1, {(AVG_W-1){1'b0}}} :
			AVG_W'(-quo_q[AVG_W-1:0]);
		else avg_val = (quo_q >= avg_lim) ? {1'b0, {(AVG_W-1){1'b1}}} : quo_q[AVG_W-1:0];
	end

	// result register, held while the result is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (cmd.fin) out_vld_q <= 1'b1;
		else if (!result_stall) out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			avg_q   <= $signed(avg_val);
			empty_q <= (wtime_q == '0);
		end
	end

	assign stat.out_busy = out_vld_q & result_stall;
	assign result_valid  = out_vld_q;
	assign average       = avg_q;
	assign time_empty    = empty_q;

endmodule

[hdl/btwa_chk.sv]
// Port-level checker for the binned time-weighted average unit, with its bind.
module btwa_chk (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  item_valid,
	input logic                                  item_stall,
	input logic                                  result_valid,
	input logic                                  result_stall,
	input logic signed [btwa_pkg::AVG_W-1:0]     average,
	input logic                                  time_empty
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(average) &&
		$stable(time_empty))
		else $error("stalled result changed");

	// an empty window reports a zero average
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && time_empty |-> average == '0)
		else $error("empty window with nonzero average");

	// an accepted item keeps the input side busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input free right after accepting an item");

	// a new result only comes out of work in flight
	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result appeared with no item in flight");

endmodule

bind binned_time_weighted_average_unit btwa_chk u_btwa_chk (.*);

[verif/binned_time_weighted_average_unit_test.sv]
// Self-checking testbench for the binned time-weighted average unit.
`timescale 1ns / 1ps

module binned_time_weighted_average_unit_test;

	localparam int SAMPLE_W      = btwa_pkg::SAMPLE_W;
	localparam int STEP_W        = btwa_pkg::STEP_W;
	localparam int PERIOD_W      = btwa_pkg::PERIOD_W;
	localparam int AVG_W         = btwa_pkg::AVG_W;
	localparam int SUM_W         = btwa_pkg::SUM_W;
	localparam int TIME_W        = btwa_pkg::TIME_W;
	localparam int WSUM_W        = btwa_pkg::WSUM_W;
	localparam int WTIME_W       = btwa_pkg::WTIME_W;

	localparam int BINS          = btwa_pkg::NUM_BINS_DEF;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 100;
	localparam int HOLD_AFTER    = 150;
	localparam int LONG_HOLD     = 600;
	localparam int DRAIN_CYCLES  = 2 * (BINS + 57);
	localparam int QUIET_LIMIT   = 5000;

	localparam longint SUM_HI   = (longint'(1) <<< (SUM_W - 1)) - 1;
	localparam longint SUM_LO   = -SUM_HI - 1;
	localparam longint WSUM_HI  = (longint'(1) <<< (WSUM_W - 1)) - 1;
	localparam longint WSUM_LO  = -WSUM_HI - 1;
	localparam longint AVG_HI   = (longint'(1) <<< (AVG_W - 1)) - 1;
	localparam longint AVG_LO   = -AVG_HI - 1;
	localparam longint unsigned TIME_HI  = (longint'(1) << TIME_W) - 1;
	localparam longint unsigned WTIME_HI = (longint'(1) << WTIME_W) - 1;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_HI = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_LO = 24'sh800000;
	localparam logic [STEP_W-1:0] STEP_HI = 16'hFFFF;

	typedef enum logic {
		ROW_ITEM,
		ROW_PERIOD
	} row_kind_t;

	// One line of the directed plan; on a period row, step holds the new bin period.
	typedef struct packed {
		row_kind_t                  kind;
		logic signed [SAMPLE_W-1:0] sample;
		logic [STEP_W-1:0]          step;
		logic                       typed;
		logic signed [AVG_W-1:0]    average;
		logic                       time_empty;
	} plan_row_t;

	typedef struct {
		logic signed [AVG_W-1:0] average;
		logic                    time_empty;
	} avg_result_t;

	localparam int PLAN_ROWS = 25;
	plan_row_t plan [PLAN_ROWS] = '{
		// empty window right after reset, zero steps
		'{ROW_ITEM,   24'sh123456, 16'd0,     1'b1, 24'sd0,      1'b1},
		'{ROW_ITEM,   24'shFFFFFF, 16'd0,     1'b1, 24'sd0,      1'b1},
		// first real step: average is the sample itself
		'{ROW_ITEM,   SAMPLE_HI,   STEP_HI,   1'b1, SAMPLE_HI,   1'b0},
		'{ROW_ITEM,   SAMPLE_LO,   STEP_HI,   1'b0, 24'sd0,      1'b0},
		'{ROW_ITEM,   -24'sd5,     16'd3,     1'b0, 24'sd0,      1'b0},
		'{ROW_ITEM,   24'sd7,      16'd0,     1'b0, 24'sd0,      1'b0},
		// zero bin period: every step advances, zero steps clear the whole ring
		'{ROW_PERIOD, 24'sd0,      16'd0,     1'b0, 24'sd0,      1'b0},
		'{ROW_ITEM,   24'sd11,     16'd0,     1'b0, 24'sd0,      1'b0},
		'{ROW_ITEM,   -24'sd300,   16'd0,     1'b0, 24'sd0,      1'b0},
		'{ROW_ITEM,   SAMPLE_HI,   16'd0,     1'b0, 24'sd0,      1'b0},
		'{ROW_ITEM,   SAMPLE_LO,   16'd0,     1'b0, 24'sd0,      1'b0},
		'{ROW_ITEM,   24'sd1,      16'd0,     1'b0, 24'sd0,      1'b0},
		'{ROW_ITEM,   24'sh555555, 16'd0,     1'b0, 24'sd0,      1'b0},
		'{ROW_ITEM,   24'shAAAAAA, 16'd0,     1'b0, 24'sd0,      1'b0},
		'{ROW_ITEM,   24'sd42,     16'd0,     1'b1, 24'sd0,      1'b1},
		// widest period: one full step fills a bin exactly
		'{ROW_PERIOD, 24'sd0,      STEP_HI,   1'b0, 24'sd0,      1'b0},
		'{ROW_ITEM,   SAMPLE_LO,   STEP_HI,   1'b1, SAMPLE_LO,   1'b0},
		'{ROW_ITEM,   24'sd3,      16'd1,     1'b0, 24'sd0,      1'b0},
		'{ROW_ITEM,   SAMPLE_HI,   16'd40000, 1'b0, 24'sd0,      1'b0},
		// shortest period: negative averages truncate toward zero
		'{ROW_PERIOD, 24'sd0,      16'd1,     1'b0, 24'sd0,      1'b0},
		'{ROW_ITEM,   24'sd1,      16'd1,     1'b0, 24'sd0,      1'b0},
		'{ROW_ITEM,   -24'sd2,     16'd2,     1'b0, 24'sd0,      1'b0},
		'{ROW_ITEM,   24'sd0,      STEP_HI,   1'b0, 24'sd0,      1'b0},
		'{ROW_ITEM,   SAMPLE_LO,   16'd1,     1'b0, 24'sd0,      1'b0},
		'{ROW_ITEM,   SAMPLE_HI,   16'd1,     1'b0, 24'sd0,      1'b0}
	};

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [PERIOD_W-1:0]        bin_period = '0;
	logic                       item_valid = 1'b0;
	logic                       item_stall;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic [STEP_W-1:0]          step_time = '0;
	logic                       result_valid;
	logic                       result_stall = 1'b0;
	logic signed [AVG_W-1:0]    average;
	logic                       time_empty;

	// typed-in expectation travelling with the offered item
	logic                       row_typed = 1'b0;
	logic signed [AVG_W-1:0]    row_average = '0;
	logic                       row_empty = 1'b0;

	// predictor state
	logic signed [SUM_W-1:0]    pred_bin_sum [BINS] = '{default: '0};
	logic [TIME_W-1:0]          pred_bin_time [BINS] = '{default: '0};
	int unsigned                pred_bin = 0;
	logic [PERIOD_W-1:0]        pred_period = btwa_pkg::PERIOD_RESET;

	avg_result_t expected_averages [$];
	int items_accepted = 0;
	int results_checked = 0;
	int mismatches = 0;
	int periods_written = 0;
	int burst_left = 0;
	int quiet_cycles = 0;
	int hold_left = 0;
	int mode_left = 0;
	int stall_odds = 0;
	bit long_hold_done = 1'b0;

	binned_time_weighted_average_unit #(
		.NUM_BINS(BINS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.bin_period(bin_period),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.sample(sample),
		.step_time(step_time),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.average(average),
		.time_empty(time_empty)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Advance the ring if the open bin is full, accumulate, then average the window.
	function automatic void predict_average(input logic signed [SAMPLE_W-1:0] s,
			input logic [STEP_W-1:0] dt, output avg_result_t res);
		longint wsum;
		longint unsigned wtime;
		longint unsigned btime;
		longint quot;

		if (pred_bin >= BINS)
			pred_bin = 0;
		if (pred_bin_time[pred_bin] >= pred_period) begin
			pred_bin = (pred_bin + 1) % BINS;
			pred_bin_sum[pred_bin] = '0;
			pred_bin_time[pred_bin] = '0;
		end
		pred_bin_sum[pred_bin] = SUM_W'(clamp_to(longint'(pred_bin_sum[pred_bin])
			+ longint'(s) * longint'(dt), SUM_LO, SUM_HI));
		btime = longint'(pred_bin_time[pred_bin]) + longint'(dt);
		if (btime > TIME_HI)
			btime = TIME_HI;
		pred_bin_time[pred_bin] = TIME_W'(btime);

		wsum = 0;
		wtime = 0;
		for (int k = 0; k < BINS; k++) begin
			wsum = clamp_to(wsum + longint'(pred_bin_sum[k]), WSUM_LO, WSUM_HI);
			wtime = wtime + longint'(pred_bin_time[k]);
			if (wtime > WTIME_HI)
				wtime = WTIME_HI;
		end

		if (wtime != 0) begin
			quot = wsum / longint'(wtime);
			res.average = AVG_W'(clamp_to(quot, AVG_LO, AVG_HI));
			res.time_empty = 1'b0;
		end else begin
			res.average = '0;
			res.time_empty = 1'b1;
		end
	endfunction

	// Track every handshake: update the predictor, queue expectations, check results.
	always @(posedge clk) begin : handshake_monitor
		avg_result_t want;
		avg_result_t got;

		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				pred_period = bin_period;
			if (item_valid && !item_stall) begin
				predict_average(sample, step_time, want);
				if (row_typed) begin
					want.average = row_average;
					want.time_empty = row_empty;
				end
				expected_averages.push_back(want);
				items_accepted++;
			end
			if (result_valid && !result_stall) begin
				got.average = average;
				got.time_empty = time_empty;
				if (expected_averages.size() == 0) begin
					$error("result with no item outstanding: average %0d, time_empty %0b",
						got.average, got.time_empty);
					mismatches++;
				end else begin
					want = expected_averages.pop_front();
					if (got.average !== want.average) begin
						$error("average: expected %0d, got %0d", want.average, got.average);
						mismatches++;
					end
					if (got.time_empty !== want.time_empty) begin
						$error("time_empty: expected %0b, got %0b",
							want.time_empty, got.time_empty);
						mismatches++;
					end
				end
				results_checked++;
			end
		end
	end

	// Stall results in random stretches, with one long hold-off to back up the block.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (!long_hold_done && results_checked >= HOLD_AFTER) begin
			long_hold_done = 1'b1;
			hold_left = LONG_HOLD - 1;
			result_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_odds = $urandom_range(0, 3);
				mode_left = $urandom_range(4, 60);
			end
			mode_left--;
			result_stall <= ($urandom_range(0, 3) < stall_odds);
		end
	end

	// End the run if no handshake happens for too long.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else if (arst_n) begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no handshake for %0d cycles, %0d results outstanding",
					quiet_cycles, expected_averages.size());
				$display("** binned_time_weighted_average_unit: FAILED **");
				$finish;
			end
		end
	end

	// Offer one item, opening a new burst after a random gap when the last one ran out.
	task automatic offer_item(input logic signed [SAMPLE_W-1:0] s, input logic [STEP_W-1:0] dt,
			input logic typed, input logic signed [AVG_W-1:0] avg, input logic empty);
		int gap;

		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_valid <= 1'b1;
		sample <= s;
		step_time <= dt;
		row_typed <= typed;
		row_average <= avg;
		row_empty <= empty;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	// Drop valid and wait until every accepted item has returned its result.
	task automatic wait_for_drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (expected_averages.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_period(input logic [PERIOD_W-1:0] value);
		cfg_valid <= 1'b1;
		bin_period <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		periods_written++;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return SAMPLE_HI;
			1: return SAMPLE_LO;
			2, 3: return SAMPLE_W'(int'($urandom_range(0, 200)) - 100);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [STEP_W-1:0] pick_step();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return STEP_HI;
			2, 3: return STEP_W'($urandom_range(1, 40));
			default: return STEP_W'($urandom);
		endcase
	endfunction

	initial begin
		logic [PERIOD_W-1:0] period;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed plan
		foreach (plan[r]) begin
			if (plan[r].kind == ROW_PERIOD) begin
				wait_for_drain();
				write_period(plan[r].step);
			end else begin
				offer_item(plan[r].sample, plan[r].step, plan[r].typed,
					plan[r].average, plan[r].time_empty);
			end
		end

		// random phases, each under its own bin period
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: period = PERIOD_W'($urandom_range(1, 300));
				1: period = '1;
				2: period = '0;
				3: period = PERIOD_W'($urandom_range(1, 3000));
				4: period = PERIOD_W'(1);
				default: period = PERIOD_W'($urandom);
			endcase
			wait_for_drain();
			write_period(period);
			repeat (PHASE_ITEMS)
				offer_item(pick_sample(), pick_step(), 1'b0, '0, 1'b0);
		end

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results for %0d items over %0d bin period settings.",
			results_checked, items_accepted, periods_written);
		$display("Included empty windows, zero and full-width periods and a long output hold.");
		if (mismatches == 0) begin
			$display("** binned_time_weighted_average_unit: PASSED **");
		end else begin
			$display("** binned_time_weighted_average_unit: FAILED **");
		end
		$finish;
	end

endmodule
